[hdl/fcd_pkg.sv]
// Shared types, codes and defaults for the round-robin CPU dispatcher.
package fcd_pkg;

    localparam int NUM_CPUS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int OP_W    = 3;
    localparam int CPU_W   = 4;
    localparam int PROC_W  = 6;
    localparam int SLICE_W = 16;
    localparam int PSTATE_W = 2;

    // Event codes
    localparam logic [OP_W-1:0] OP_WAKE      = 3'd0;
    localparam logic [OP_W-1:0] OP_PREEMPT   = 3'd1;
    localparam logic [OP_W-1:0] OP_YIELD     = 3'd2;
    localparam logic [OP_W-1:0] OP_TERMINATE = 3'd3;
    localparam logic [OP_W-1:0] OP_IDLE      = 3'd4;

    // New state of a displaced process
    localparam logic [PSTATE_W-1:0] PS_READY      = 2'd0;
    localparam logic [PSTATE_W-1:0] PS_WAITING    = 2'd1;
    localparam logic [PSTATE_W-1:0] PS_TERMINATED = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } fcd_cmd_t;

    typedef struct packed {
        logic has_result;
    } fcd_status_t;

    typedef struct packed {
        logic [CPU_W-1:0]    target_cpu;
        logic                dispatch_valid;
        logic [PROC_W-1:0]   dispatched_process;
        logic [SLICE_W-1:0]  slice_given;
        logic                displaced_valid;
        logic [PROC_W-1:0]   displaced_process;
        logic [PSTATE_W-1:0] displaced_state;
        logic                queue_overflow;
    } fcd_result_t;

endpackage

[hdl/fcd_in_if.sv]
// Scheduler event channel: valid, ready and the event payload.
interface fcd_in_if;
    import fcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CPU_W-1:0]  cpu_index;
    logic [PROC_W-1:0] process_number;

    modport source (output valid, output operation, output cpu_index,
                    output process_number, input ready);
    modport sink   (input valid, input operation, input cpu_index,
                    input process_number, output ready);
endinterface

[hdl/fcd_out_if.sv]
// Context switch channel: valid, ready and the dispatch report payload.
interface fcd_out_if;
    import fcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CPU_W-1:0]    target_cpu;
    logic                dispatch_valid;
    logic [PROC_W-1:0]   dispatched_process;
    logic [SLICE_W-1:0]  slice_given;
    logic                displaced_valid;
    logic [PROC_W-1:0]   displaced_process;
    logic [PSTATE_W-1:0] displaced_state;
    logic                queue_overflow;

    modport source (output valid, output target_cpu, output dispatch_valid,
                    output dispatched_process, output slice_given,
                    output displaced_valid, output displaced_process,
                    output displaced_state, output queue_overflow, input ready);
    modport sink   (input valid, input target_cpu, input dispatch_valid,
                    input dispatched_process, input slice_given,
                    input displaced_valid, input displaced_process,
                    input displaced_state, input queue_overflow, output ready);
endinterface

[hdl/fcd_ctrl.sv]
// Dispatcher controller: event sequencing and output valid tracking.
module fcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  fcd_pkg::fcd_status_t status,
    output fcd_pkg::fcd_cmd_t    cmd
);
    import fcd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    // Commit only when the result register is free or being drained.
    assign cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = status.has_result;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("capture not followed by execute");
    a_rise_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid rose without commit");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.commit)
        else $error("commit would overwrite a pending result");
`endif
endmodule

[hdl/fcd_datapath.sv]
// Dispatcher datapath: ready ring memory, CPU table, waiting mask, result register.
module fcd_datapath #(
    parameter int NUM_CPUS    = fcd_pkg::NUM_CPUS_DEF,
    parameter int QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcd_pkg::fcd_cmd_t             cmd,
    output fcd_pkg::fcd_status_t          status,
    input  logic                          cfg_we,
    input  logic [fcd_pkg::SLICE_W-1:0]   cfg_data,
    input  logic [fcd_pkg::OP_W-1:0]      operation,
    input  logic [fcd_pkg::CPU_W-1:0]     cpu_index,
    input  logic [fcd_pkg::PROC_W-1:0]    process_number,
    output fcd_pkg::fcd_result_t          result
);
    import fcd_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CIDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [PROC_W-1:0] ring_mem [QUEUE_DEPTH];
    logic [PROC_W-1:0] head_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic              run_valid_reg [NUM_CPUS];
    logic [PROC_W-1:0] run_proc_reg  [NUM_CPUS];
    logic [NUM_CPUS-1:0] waiting_reg, waiting_next;
    logic [SLICE_W-1:0]   slice_reg;

    logic [OP_W-1:0]   op_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [PROC_W-1:0] proc_reg;
    fcd_result_t       result_reg, result_next;

    logic [CIDX_W-1:0] cidx, pl_idx;
    logic              cpu_ok, had, empty, full;
    logic [PROC_W-1:0] cur;
    logic              wait_any;
    logic [CPU_W-1:0]  wait_cpu;

    logic                push, pop, set_wait, has_res, ovf;
    logic [PROC_W-1:0]   push_data;
    logic                pl_en, pl_dv, dsp_v;
    logic [CPU_W-1:0]    pl_cpu;
    logic [PROC_W-1:0]   pl_dp, dsp_p;
    logic [PSTATE_W-1:0] dsp_st;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + 1'b1;
    endfunction

    assign cidx   = cpu_reg[CIDX_W-1:0];
    assign pl_idx = pl_cpu[CIDX_W-1:0];
    assign cpu_ok = ({1'b0, cpu_reg} < (CPU_W + 1)'(NUM_CPUS));
    assign had    = cpu_ok ? run_valid_reg[cidx] : 1'b0;
    assign cur    = cpu_ok ? run_proc_reg[cidx] : '0;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Lowest-numbered waiting CPU
    always_comb
    begin
        wait_any = 1'b0;
        wait_cpu = '0;
        for (int c = NUM_CPUS - 1; c >= 0; c--)
        begin
            if (waiting_reg[c])
            begin
                wait_any = 1'b1;
                wait_cpu = CPU_W'(c);
            end
        end
    end

    always_comb
    begin
        push      = 1'b0;
        push_data = proc_reg;
        pop       = 1'b0;
        set_wait  = 1'b0;
        pl_en     = 1'b0;
        pl_cpu    = cpu_reg;
        pl_dv     = 1'b0;
        pl_dp     = '0;
        dsp_v     = 1'b0;
        dsp_p     = '0;
        dsp_st    = PS_READY;
        ovf       = 1'b0;
        case (op_reg)
            OP_WAKE:
            begin
                if (full)
                begin
                    ovf    = 1'b1;
                    pl_cpu = '0;
                end
                else
                begin
                    push = 1'b1;
                    if (wait_any)
                    begin
                        pop    = 1'b1;
                        pl_en  = 1'b1;
                        pl_cpu = wait_cpu;
                        pl_dv  = 1'b1;
                        pl_dp  = empty ? proc_reg : head_data_reg;
                    end
                end
            end
            OP_IDLE:
            begin
                if (cpu_ok && !had)
                begin
                    if (!empty)
                    begin
                        pop   = 1'b1;
                        pl_en = 1'b1;
                        pl_dv = 1'b1;
                        pl_dp = head_data_reg;
                    end
                    else
                    begin
                        set_wait = 1'b1;
                    end
                end
            end
            OP_PREEMPT:
            begin
                if (cpu_ok)
                begin
                    pl_en = 1'b1;
                    if (had)
                    begin
                        dsp_v = 1'b1;
                        dsp_p = cur;
                        pl_dv = 1'b1;
                        if (!empty)
                        begin
                            pop       = 1'b1;
                            push      = 1'b1;
                            push_data = cur;
                            pl_dp     = head_data_reg;
                        end
                        else
                        begin
                            pl_dp = cur;
                        end
                    end
                    else if (!empty)
                    begin
                        pop   = 1'b1;
                        pl_dv = 1'b1;
                        pl_dp = head_data_reg;
                    end
                end
            end
            OP_YIELD, OP_TERMINATE:
            begin
                if (cpu_ok)
                begin
                    pl_en  = 1'b1;
                    dsp_v  = had;
                    dsp_p  = cur;
                    dsp_st = (op_reg == OP_YIELD) ? PS_WAITING : PS_TERMINATED;
                    if (!empty)
                    begin
                        pop   = 1'b1;
                        pl_dv = 1'b1;
                        pl_dp = head_data_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase

        has_res = pl_en || ovf;

        result_next.target_cpu         = pl_cpu;
        result_next.dispatch_valid     = pl_dv;
        result_next.dispatched_process = pl_dv ? pl_dp : '0;
        result_next.slice_given        = pl_dv ? slice_reg : '0;
        result_next.displaced_valid    = dsp_v;
        result_next.displaced_process  = dsp_v ? dsp_p : '0;
        result_next.displaced_state    = dsp_v ? dsp_st : PS_READY;
        result_next.queue_overflow     = ovf;

        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);

        waiting_next = waiting_reg;
        if (set_wait)
            waiting_next = waiting_next | (NUM_CPUS'(1) << cidx);
        if (pl_en && pl_dv)
            waiting_next = waiting_next & ~(NUM_CPUS'(1) << pl_idx);
    end

    assign status.has_result = has_res;
    assign result            = result_reg;

    // Ring memory: write at the tail on commit, read the head on capture.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && push)
            ring_mem[tail_reg] <= push_data;
        if (cmd.capture)
            head_data_reg <= ring_mem[head_reg];
    end

    // Event and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            cpu_reg  <= cpu_index;
            proc_reg <= process_number;
        end
        if (cmd.commit && has_res)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            waiting_reg <= '0;
            slice_reg   <= '0;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                run_valid_reg[c] <= 1'b0;
                run_proc_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                slice_reg <= cfg_data;
            if (cmd.commit)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                waiting_reg <= waiting_next;
                if (pl_en)
                begin
                    run_valid_reg[pl_idx] <= pl_dv;
                    run_proc_reg[pl_idx]  <= pl_dv ? pl_dp : '0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ready ring count exceeds depth");
    a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (waiting_reg != '0) |-> (count_reg == '0))
        else $error("CPU waiting while ready ring holds work");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("ready ring pointers apart while empty");
`endif
endmodule

[hdl/fifo_round_robin_cpu_dispatcher_top.sv]
// Top level of the round-robin ready-queue CPU dispatcher.
//
// Usage:
//   events   : scheduler events (wake up, preempt, yield, terminate, idle)
//              with the CPU and process they concern; one transfer per event.
//   switches : context switch reports; at most one transfer per event.
//   cfg_we / cfg_data : write the time slice register, only while idle.
// Timing: an event is taken in the idle state and the ring head is read at
// that edge; the execute state then computes the dispatch, updates the ring
// pointers, CPU table and waiting mask, and loads the result register. A
// result is offered from that register after the commit; no new event is
// taken before it. Each event makes a single read-then-write ring pass.
// Stall: while a result waits on switches the next event is still taken;
// its commit holds until the result register is drained.
// Reset: the ring is empty, every CPU idle, no CPU waiting, slice zero.
// The ring contents are not cleared; only queued entries are ever read.
module fifo_round_robin_cpu_dispatcher_top #(
    parameter int NUM_CPUS    = fcd_pkg::NUM_CPUS_DEF,
    parameter int QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fcd_in_if.sink                      events,
    fcd_out_if.source                   switches,
    input  logic                        cfg_we,
    input  logic [fcd_pkg::SLICE_W-1:0] cfg_data
);
    import fcd_pkg::*;

    fcd_cmd_t    cmd;
    fcd_status_t status;
    fcd_result_t result;

    // Sequence each event: take it, then commit once the output is free.
    fcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_valid (switches.valid),
        .out_ready (switches.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the queue, CPU table and result register.
    fcd_datapath #(
        .NUM_CPUS    (NUM_CPUS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .operation      (events.operation),
        .cpu_index      (events.cpu_index),
        .process_number (events.process_number),
        .result         (result)
    );

    // Drive the report fields straight from the result register.
    assign switches.target_cpu         = result.target_cpu;
    assign switches.dispatch_valid     = result.dispatch_valid;
    assign switches.dispatched_process = result.dispatched_process;
    assign switches.slice_given        = result.slice_given;
    assign switches.displaced_valid    = result.displaced_valid;
    assign switches.displaced_process  = result.displaced_process;
    assign switches.displaced_state    = result.displaced_state;
    assign switches.queue_overflow     = result.queue_overflow;

endmodule
